@@ sv/haaqi_pkg.sv @@
// Shared types, widths and segment tables for the hourly average AQI classifier.
// Depends on nothing; every other file of the block but haaqi_ram imports it.

package haaqi_pkg;

    // Field widths of the stream items and the configuration register
    localparam int ID_W   = 5;
    localparam int TIME_W = 32;
    localparam int CONC_W = 13;
    localparam int WIN_W  = 17;
    localparam int CNT_W  = 16;
    localparam int SUM_W  = 32;
    localparam int MEAN_W = 16;
    localparam int AQI_W  = 10;
    localparam int CAT_W  = 3;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;

    // Defaults for the top-level parameters and the register reset
    localparam int SENSOR_SLOTS_DEF = 16;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 17'd3600;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Segment codes; a category is a segment code or the invalid code
    localparam int SEG_W = 3;
    localparam int BP_W  = 13;
    localparam logic [SEG_W-1:0] SEG_FIRST = 3'd0;
    localparam logic [SEG_W-1:0] SEG_LAST  = 3'd6;
    localparam logic [SEG_W-1:0] SEG_NONE  = 3'd7;
    localparam logic [CAT_W-1:0] CAT_INVALID = 3'd7;
    localparam logic [BP_W-1:0]  CAT_TOP_LIMIT = 13'd5005;

    // Shared divider sizes: dividend covers sum*100, divisor covers width*count
    localparam int DVD_W     = 39;
    localparam int DVS_W     = 27;
    localparam int DIV_CNT_W = 6;

    localparam int QUEUE_DEPTH = 2;

    // Per-sensor window record held in the slot memory
    typedef struct packed {
        logic [TIME_W-1:0] win_start;
        logic [TIME_W-1:0] win_last;
        logic [CNT_W-1:0]  count;
        logic [SUM_W-1:0]  sum;
    } slot_rec_t;

    // A closed window handed from the front end to the back end
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  count;
    } job_t;

    typedef enum logic {
        FR_IDLE,
        FR_UPDATE
    } fr_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SEG,
        BK_TOP,
        BK_MEAN,
        BK_MEAN_WAIT,
        BK_SCALE,
        BK_NUM,
        BK_AQI,
        BK_AQI_WAIT,
        BK_DONE
    } bk_state_t;

    // Upper breakpoint of a segment, in tenths
    function automatic logic [BP_W-1:0] seg_hi(input logic [SEG_W-1:0] seg);
        logic [BP_W-1:0] r;
        unique case (seg)
            3'd0:    r = 13'd120;
            3'd1:    r = 13'd355;
            3'd2:    r = 13'd555;
            3'd3:    r = 13'd1505;
            3'd4:    r = 13'd2505;
            3'd5:    r = 13'd3505;
            3'd6:    r = 13'd5505;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Lower breakpoint of a segment, in tenths
    function automatic logic [BP_W-1:0] seg_lo(input logic [SEG_W-1:0] seg);
        logic [BP_W-1:0] r;
        unique case (seg)
            3'd0:    r = 13'd0;
            3'd1:    r = 13'd120;
            3'd2:    r = 13'd355;
            3'd3:    r = 13'd555;
            3'd4:    r = 13'd1505;
            3'd5:    r = 13'd2505;
            3'd6:    r = 13'd3505;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Breakpoint distance hi - lo of a segment, in tenths
    function automatic logic [10:0] seg_width(input logic [SEG_W-1:0] seg);
        logic [10:0] r;
        unique case (seg)
            3'd0:    r = 11'd120;
            3'd1:    r = 11'd235;
            3'd2:    r = 11'd200;
            3'd3:    r = 11'd950;
            3'd4:    r = 11'd1000;
            3'd5:    r = 11'd1000;
            3'd6:    r = 11'd2000;
            default: r = 11'd1;
        endcase
        return r;
    endfunction

    // AQI at the lower breakpoint of a segment
    function automatic logic [8:0] seg_base(input logic [SEG_W-1:0] seg);
        logic [8:0] r;
        unique case (seg)
            3'd0:    r = 9'd0;
            3'd1:    r = 9'd50;
            3'd2:    r = 9'd100;
            3'd3:    r = 9'd150;
            3'd4:    r = 9'd200;
            3'd5:    r = 9'd300;
            3'd6:    r = 9'd400;
            default: r = '0;
        endcase
        return r;
    endfunction

    // AQI range covered by a segment
    function automatic logic [6:0] seg_span(input logic [SEG_W-1:0] seg);
        logic [6:0] r;
        unique case (seg)
            3'd0, 3'd1, 3'd2, 3'd3: r = 7'd50;
            3'd4, 3'd5, 3'd6:       r = 7'd100;
            default:                r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/haaqi_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.

module haaqi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/haaqi_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the mean and AQI steps.
// Depends on haaqi_pkg for the operand widths.

module haaqi_div import haaqi_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] trial_sub;
    logic           trial_ge;

    // One restoring step: shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        trial_ge  = trial >= {1'b0, dvs_reg};
        trial_sub = trial - {1'b0, dvs_reg};
    end

    // Control: iteration count and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits enter at the bottom as dividend bits leave the top
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], trial_ge};
            rem_reg <= trial_ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

@@ sv/haaqi_front.sv @@
// Front end: accepts samples, updates the per-sensor window record and
// hands closed windows to the queue. Depends on haaqi_pkg and haaqi_ram.

module haaqi_front import haaqi_pkg::*; #(
    parameter int SENSOR_SLOTS = SENSOR_SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [WIN_W-1:0]     window_seconds,
    output logic                 push_valid,
    input  logic                 push_ready,
    output job_t                 push_job
);

    localparam int SLOT_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
    localparam int REC_W  = $bits(slot_rec_t);

    fr_state_t state_reg, state_next;

    logic [ID_W-1:0]         id_reg;
    logic [TIME_W-1:0]       time_reg;
    logic [CONC_W-1:0]       conc_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [SENSOR_SLOTS-1:0] valid_reg;

    logic [ID_W-1:0]   in_id;
    logic [TIME_W-1:0] in_time;
    logic [CONC_W-1:0] in_conc;
    logic              in_ok;
    logic [SLOT_W-1:0] in_slot;
    logic              take;

    logic [REC_W-1:0] ram_rdata;
    slot_rec_t        cur_rec;
    slot_rec_t        new_rec;
    logic [TIME_W:0]  diff;
    logic             close;
    logic             proceed;
    logic             wr_en;

    // Input fields and range check of the one-based sensor id
    assign in_id   = s_tdata[ID_W-1:0];
    assign in_time = s_tdata[ID_W +: TIME_W];
    assign in_conc = s_tdata[ID_W+TIME_W +: CONC_W];
    assign in_ok   = (in_id != '0) && (32'(in_id) <= 32'(SENSOR_SLOTS));
    assign in_slot = SLOT_W'(32'(in_id) - 32'd1);
    assign take    = s_tvalid && s_tready && in_ok;

    // Slot record memory; entries that are not valid read as an empty window
    haaqi_ram #(
        .WIDTH (REC_W),
        .DEPTH (SENSOR_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (slot_reg),
        .wdata (new_rec),
        .re    (take),
        .raddr (in_slot),
        .rdata (ram_rdata)
    );

    // Record update for the sample held in the input registers
    always_comb
    begin
        cur_rec = valid_reg[slot_reg] ? slot_rec_t'(ram_rdata) : '0;
        new_rec = cur_rec;
        if (cur_rec.win_start == '0)
        begin
            new_rec.win_start = time_reg;
        end
        else
        begin
            new_rec.win_last = time_reg;
        end
        if (cur_rec.count != CNT_MAX)
        begin
            new_rec.count = cur_rec.count + 1'b1;
            new_rec.sum   = cur_rec.sum + SUM_W'(conc_reg);
        end
        diff    = {1'b0, new_rec.win_last} - {1'b0, new_rec.win_start};
        close   = $signed(diff) >= $signed((TIME_W+1)'(window_seconds));
        proceed = !close || push_ready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE:
            begin
                if (take)
                begin
                    state_next = FR_UPDATE;
                end
            end
            FR_UPDATE:
            begin
                if (proceed)
                begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        s_tready   = 1'b0;
        wr_en      = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            FR_IDLE:
            begin
                s_tready = 1'b1;
            end
            FR_UPDATE:
            begin
                wr_en      = proceed && !close;
                push_valid = close;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign push_job.id    = id_reg;
    assign push_job.stamp = time_reg;
    assign push_job.sum   = new_rec.sum;
    assign push_job.count = new_rec.count;

    // Control state and slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == FR_UPDATE && proceed)
            begin
                valid_reg[slot_reg] <= !close;
            end
        end
    end

    // Sample registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            id_reg   <= in_id;
            time_reg <= in_time;
            conc_reg <= in_conc;
            slot_reg <= in_slot;
        end
    end

endmodule

@@ sv/haaqi_queue.sv @@
// Short queue of closed windows between the front end and the back end.
// Depends on haaqi_pkg for the job type and depth.

module haaqi_queue import haaqi_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = fill_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = mem_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ sv/haaqi_back.sv @@
// Back end: classifies a closed window, computes mean and AQI with the shared
// divider and holds the result in the output register. Depends on haaqi_pkg, haaqi_div.

module haaqi_back import haaqi_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  job_t                 job,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    bk_state_t state_reg, state_next;

    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] stamp_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SEG_W-1:0]  seg_reg;
    logic [CAT_W-1:0]  cat_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [AQI_W-1:0]  aqi_reg;
    logic [27:0]       lo_cnt_reg;
    logic [DVS_W-1:0]  den_reg;
    logic [DVD_W-1:0]  num_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic             out_free;
    logic             div_start;
    logic             div_done;
    logic [DVD_W-1:0] div_q;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;

    logic [28:0]       hi_prod;
    logic [28:0]       top_prod;
    logic              sum_lt;
    logic              sum_le;
    logic              top_over;
    logic [35:0]       sum_x10;
    logic [27:0]       lo_prod;
    logic [DVS_W-1:0]  den_prod;
    logic [DVD_W-1:0]  num_prod;
    logic [MEAN_W-1:0] mean_sat;
    logic [AQI_W-1:0]  aqi_val;

    assign out_free = !m_tvalid_reg || m_tready;

    // Segment search compares the sum with one breakpoint times count per cycle
    always_comb
    begin
        hi_prod  = 29'(seg_hi(seg_reg)) * 29'(cnt_reg);
        top_prod = 29'(CAT_TOP_LIMIT) * 29'(cnt_reg);
        sum_lt   = sum_reg <  SUM_W'(hi_prod);
        sum_le   = sum_reg <= SUM_W'(hi_prod);
        top_over = sum_reg >  SUM_W'(top_prod);
    end

    // Operand preparation for the mean and AQI divisions
    always_comb
    begin
        sum_x10  = 36'({sum_reg, 3'b000}) + 36'({sum_reg, 1'b0});
        lo_prod  = 28'(seg_lo(seg_reg)) * 28'(cnt_reg);
        den_prod = DVS_W'(seg_width(seg_reg)) * DVS_W'(cnt_reg);
        num_prod = DVD_W'(sum_reg - SUM_W'(lo_cnt_reg)) * DVD_W'(seg_span(seg_reg));
        div_dividend = (state_reg == BK_MEAN) ? DVD_W'(sum_x10) : num_reg;
        div_divisor  = (state_reg == BK_MEAN) ? DVS_W'(cnt_reg) : den_reg;
        mean_sat = (div_q > DVD_W'({MEAN_W{1'b1}})) ? '1 : div_q[MEAN_W-1:0];
        aqi_val  = AQI_W'(seg_base(seg_reg)) + div_q[AQI_W-1:0];
    end

    haaqi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = BK_SEG;
                end
            end
            BK_SEG:
            begin
                if (seg_reg == SEG_LAST)
                begin
                    state_next = sum_le ? BK_TOP : BK_MEAN;
                end
                else if (sum_lt)
                begin
                    state_next = BK_MEAN;
                end
            end
            BK_TOP:       state_next = BK_MEAN;
            BK_MEAN:      state_next = BK_MEAN_WAIT;
            BK_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (seg_reg == SEG_NONE) ? BK_DONE : BK_SCALE;
                end
            end
            BK_SCALE:     state_next = BK_NUM;
            BK_NUM:       state_next = BK_AQI;
            BK_AQI:       state_next = BK_AQI_WAIT;
            BK_AQI_WAIT:
            begin
                if (div_done)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        job_ready = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            BK_IDLE:         job_ready = 1'b1;
            BK_MEAN, BK_AQI: div_start = 1'b1;
            default:
            begin
                job_ready = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    // Control state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the current window
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    id_reg    <= job.id;
                    stamp_reg <= job.stamp;
                    sum_reg   <= job.sum;
                    cnt_reg   <= job.count;
                    seg_reg   <= SEG_FIRST;
                end
            end
            BK_SEG:
            begin
                if (seg_reg == SEG_LAST)
                begin
                    if (!sum_le)
                    begin
                        seg_reg <= SEG_NONE;
                        cat_reg <= CAT_INVALID;
                    end
                end
                else if (sum_lt)
                begin
                    cat_reg <= CAT_W'(seg_reg);
                end
                else
                begin
                    seg_reg <= seg_reg + 1'b1;
                end
            end
            BK_TOP:
            begin
                cat_reg <= top_over ? CAT_INVALID : CAT_W'(SEG_LAST);
            end
            BK_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    mean_reg <= mean_sat;
                    if (seg_reg == SEG_NONE)
                    begin
                        aqi_reg <= '1;
                    end
                end
            end
            BK_SCALE:
            begin
                lo_cnt_reg <= lo_prod;
                den_reg    <= den_prod;
            end
            BK_NUM:
            begin
                num_reg <= num_prod;
            end
            BK_AQI_WAIT:
            begin
                if (div_done)
                begin
                    aqi_reg <= aqi_val;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {6'b0, cat_reg, aqi_reg, mean_reg, stamp_reg, id_reg};
                end
            end
            default:
            begin
                num_reg <= num_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ sv/hourly_average_aqi_classifier_unit.sv @@
// Hourly average AQI classifier: front end, window queue and back end.
// Depends on haaqi_pkg, haaqi_front, haaqi_queue and haaqi_back.
// Samples are taken one at a time: each is accepted, then its slot record is read, updated and
// written back before the next sample is accepted. A result passes a segment search and two
// passes (start, iterations, done) of the shared bit-serial divider, one for the mean and one
// for the AQI; the AQI pass is skipped when the mean lies above the top breakpoint. A closed
// window holds the back end until its result is in the output register; once the queue is
// full, a closing sample stalls the input.
// Reset clears all slot valid bits at once (no clearing pass) and sets the window to 3600 s.

module hourly_average_aqi_classifier_unit import haaqi_pkg::*; #(
    parameter int SENSOR_SLOTS = SENSOR_SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // s_tdata: sensor_id[4:0], sample_time[36:5], concentration[49:37], zero[55:50]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata: out_sensor_id[4:0], close_time[36:5], mean_concentration[52:37],
    //          aqi[62:53], category[65:63], zero[71:66]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [WIN_W-1:0]     cfg_wdata
);

    logic [WIN_W-1:0] window_seconds_reg;

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    // Window length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_seconds_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_seconds_reg <= cfg_wdata;
        end
    end

    haaqi_front #(
        .SENSOR_SLOTS (SENSOR_SLOTS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .window_seconds (window_seconds_reg),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_job       (push_job)
    );

    haaqi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    haaqi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
